// ----- design/assert_macros.svh -----
// assertion macros shared by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check an implication on every clock edge outside reset
`define CHK_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// check an implication in the next cycle
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// ----- design/rbsi_pkg.sv -----
// shared types and constants for the roi background subtracted intensity unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rbsi_pkg;
  localparam int MaxPixels = 262144;
  localparam int AddrBits = 18;
  localparam int PixelBits = 16;
  localparam int MaxRoi = 4096;
  localparam int CountBits = 13;
  localparam int SumBits = 28;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_BG = 2'd1,
    MODE_ROI = 2'd2,
    MODE_FINISH = 2'd3
  } mode_t;

  localparam logic [1:0] REG_WIDTH = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_XDRIFT = 2'd2;
  localparam logic [1:0] REG_YDRIFT = 2'd3;

  // command passed from the front to the back through the queue
  typedef struct packed {
    mode_t mode;
    logic inb;
    logic [AddrBits-1:0] addr;
    logic [PixelBits-1:0] value;
  } cmd_t;
endpackage
`default_nettype wire

// ----- design/roi_background_subtracted_intensity_unit.sv -----
// top level of the roi background subtracted intensity unit
// depends on rbsi_pkg, rbsi_front, rbsi_queue, rbsi_back
`timescale 1ns / 1ps
`default_nettype none
// loads a frame into a 256k x 16 store (mode 0), then sums background (mode 1)
// and roi (mode 2) pixels picked by linear index after drift correction; a
// finish word (mode 3) returns mean and background subtracted amplitude.
// the front accepts a load word, then hands it to the queue; an index word
// goes through the 18 step bit serial split of the index by the width, a
// bounds check and a hand-off, and no new word is taken until it is handed
// off; the back end reads the store, then accumulates. a finish result is
// offered after the 33 step bit serial division for the mean and a multiply.
// front and back run apart through a two entry queue, so a load can overlap
// index decode.
module roi_background_subtracted_intensity_unit (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  output logic s_tready,
  // mode[1:0], pixel_index[19:2], pixel_value[35:20], zero pad to 40
  input wire logic [39:0] s_tdata,
  output logic m_tvalid,
  input wire logic m_tready,
  // amplitude[32:0], background_mean[52:33], roi_pixel_count[65:53],
  // background_pixel_count[78:66], valid_res[79]
  output logic [79:0] m_tdata,
  input wire logic cfg_we,
  input wire logic [1:0] cfg_index,
  input wire logic [9:0] cfg_data
);
  logic [9:0] width, height;
  logic signed [9:0] xdrift, ydrift;
  logic fq_valid, fq_ready, qb_valid, qb_ready;
  rbsi_pkg::cmd_t fq_cmd, qb_cmd;
  logic [79:0] res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width <= 10'd512;
      height <= 10'd512;
      xdrift <= '0;
      ydrift <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rbsi_pkg::REG_WIDTH: width <= cfg_data;
        rbsi_pkg::REG_HEIGHT: height <= cfg_data;
        rbsi_pkg::REG_XDRIFT: xdrift <= cfg_data;
        rbsi_pkg::REG_YDRIFT: ydrift <= cfg_data;
        default: ;
      endcase
    end
  end

  rbsi_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .in_mode(s_tdata[1:0]), .in_index(s_tdata[19:2]), .in_value(s_tdata[35:20]),
    .width(width), .height(height), .xdrift(xdrift), .ydrift(ydrift),
    .cmd_valid(fq_valid), .cmd_ready(fq_ready), .cmd(fq_cmd)
  );

  rbsi_queue u_queue (
    .clk(clk), .rst(rst), .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_cmd),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_cmd)
  );

  rbsi_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(qb_valid), .cmd_ready(qb_ready), .cmd(qb_cmd),
    .res_valid(m_tvalid), .res_ready(m_tready), .res_data(res)
  );

  // result word: 80 bits, fields packed from the low end
  assign m_tdata = res;
endmodule
`default_nettype wire

// ----- design/rbsi_ram.sv -----
// generic simple dual port ram (one write port, one read port) with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module rbsi_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(Depth)-1:0] waddr,
  input wire logic [Width-1:0] wdata,
  input wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- design/rbsi_front.sv -----
// front end: splits an index into x and y over cycles, shifts by drift, bounds checks
// depends on rbsi_pkg
`timescale 1ns / 1ps
`default_nettype none
module rbsi_front (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  input wire logic [1:0] in_mode,
  input wire logic [rbsi_pkg::AddrBits-1:0] in_index,
  input wire logic [rbsi_pkg::PixelBits-1:0] in_value,
  input wire logic [9:0] width,
  input wire logic [9:0] height,
  input wire logic signed [9:0] xdrift,
  input wire logic signed [9:0] ydrift,
  output logic cmd_valid,
  input wire logic cmd_ready,
  output rbsi_pkg::cmd_t cmd
);
  typedef enum logic [1:0] {S_IDLE, S_DIV, S_CHECK, S_OUT} state_t;
  state_t state;
  logic [4:0] step;
  logic [rbsi_pkg::AddrBits-1:0] quo;
  logic [9:0] rem;
  logic [rbsi_pkg::AddrBits-1:0] idx;
  rbsi_pkg::cmd_t hold;
  logic [10:0] trial;
  logic signed [19:0] xs, ys;
  logic [28:0] addr_full;

  assign in_ready = (state == S_IDLE);
  assign cmd_valid = (state == S_OUT);
  assign cmd = hold;
  // restoring division, one quotient bit per cycle
  assign trial = {rem, idx[rbsi_pkg::AddrBits-1]};
  assign xs = 20'(signed'({10'd0, rem})) - 20'(xdrift);
  assign ys = 20'(signed'({2'd0, quo})) - 20'(ydrift);
  assign addr_full = 29'(ys[18:0]) * 29'(width) + 29'(xs[18:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            hold.mode <= rbsi_pkg::mode_t'(in_mode);
            hold.value <= in_value;
            hold.addr <= in_index;
            hold.inb <= 1'b1;
            idx <= in_index;
            rem <= '0;
            quo <= '0;
            step <= '0;
            if (in_mode == rbsi_pkg::MODE_BG || in_mode == rbsi_pkg::MODE_ROI) begin
              state <= S_DIV;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_DIV: begin
          if (width == 10'd0) begin
            hold.inb <= 1'b0;
            state <= S_OUT;
          end else begin
            if (trial >= {1'b0, width}) begin
              rem <= 10'(trial - {1'b0, width});
              quo <= {quo[rbsi_pkg::AddrBits-2:0], 1'b1};
            end else begin
              rem <= trial[9:0];
              quo <= {quo[rbsi_pkg::AddrBits-2:0], 1'b0};
            end
            idx <= {idx[rbsi_pkg::AddrBits-2:0], 1'b0};
            step <= step + 5'd1;
            if (step == 5'(rbsi_pkg::AddrBits - 1)) begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          hold.inb <= !(xs < 0 || xs >= 20'(width) || ys < 0 || ys >= 20'(height)
                      || addr_full >= 29'(rbsi_pkg::MaxPixels));
          hold.addr <= addr_full[rbsi_pkg::AddrBits-1:0];
          state <= S_OUT;
        end
        S_OUT: begin
          if (cmd_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- design/rbsi_queue.sv -----
// two entry fifo between front and back
// depends on rbsi_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rbsi_queue (
  input wire logic clk,
  input wire logic rst,
  input wire logic wr_valid,
  output logic wr_ready,
  input wire rbsi_pkg::cmd_t wr_data,
  output logic rd_valid,
  input wire logic rd_ready,
  output rbsi_pkg::cmd_t rd_data
);
  rbsi_pkg::cmd_t slot [2];
  logic wptr, rptr;
  logic [1:0] fill;
  logic push, pop;
  assign wr_ready = fill != 2'd2;
  assign rd_valid = fill != 2'd0;
  assign rd_data = slot[rptr];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= wr_data;
    end
  end
  `CHK_IMPL(fill_bound, 1'b1, fill <= 2'd2)
  `CHK_NEXT(full_holds, fill == 2'd2 && !pop, fill == 2'd2)
endmodule
`default_nettype wire

// ----- design/rbsi_back.sv -----
// back end: frame store, accumulation and the finish computation
// depends on rbsi_pkg, rbsi_ram and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rbsi_back (
  input wire logic clk,
  input wire logic rst,
  input wire logic cmd_valid,
  output logic cmd_ready,
  input wire rbsi_pkg::cmd_t cmd,
  output logic res_valid,
  input wire logic res_ready,
  output logic [79:0] res_data
);
  typedef enum logic [2:0] {B_IDLE, B_ACC, B_DIV, B_MUL, B_OUT} state_t;
  state_t state;
  rbsi_pkg::mode_t mode;
  logic [rbsi_pkg::PixelBits-1:0] rdata;
  logic [rbsi_pkg::SumBits-1:0] rsum, bsum;
  logic [rbsi_pkg::CountBits-1:0] rcnt, bcnt;
  // division state: dividend bsum*16 + bcnt/2, 33 bits
  logic [32:0] dvd;
  logic [13:0] drem;
  logic [32:0] dquo;
  logic [5:0] dstep;
  logic [14:0] dtrial;
  logic [19:0] mean;
  logic [32:0] prod;
  logic [32:0] amp;
  logic ok;
  logic we;

  // the store is read at the edge that pops the word, data is ready in B_ACC
  assign we = cmd_valid && cmd_ready && cmd.mode == rbsi_pkg::MODE_LOAD;
  rbsi_ram #(.Width(rbsi_pkg::PixelBits), .Depth(rbsi_pkg::MaxPixels)) u_store (
    .clk(clk), .we(we), .waddr(cmd.addr), .wdata(cmd.value),
    .raddr(cmd.addr), .rdata(rdata)
  );

  assign cmd_ready = (state == B_IDLE);
  assign res_valid = (state == B_OUT);
  assign dtrial = {drem, dvd[32]};
  assign amp = ok ? ({1'b0, rsum, 4'd0} - prod) : '0;
  assign res_data = {ok, bcnt, rcnt, mean, amp};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      rsum <= '0;
      bsum <= '0;
      rcnt <= '0;
      bcnt <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (cmd_valid) begin
            mode <= cmd.mode;
            if (cmd.mode == rbsi_pkg::MODE_FINISH) begin
              ok <= rcnt != '0 && bcnt != '0;
              dvd <= {1'b0, bsum, 4'd0} + 33'(bcnt[12:1]);
              drem <= '0;
              dquo <= '0;
              dstep <= '0;
              state <= B_DIV;
            end else if (cmd.mode != rbsi_pkg::MODE_LOAD && cmd.inb) begin
              state <= B_ACC;
            end
          end
        end
        B_ACC: begin
          if (mode == rbsi_pkg::MODE_BG && bcnt < 13'(rbsi_pkg::MaxRoi)) begin
            bsum <= bsum + 28'(rdata);
            bcnt <= bcnt + 13'd1;
          end
          if (mode == rbsi_pkg::MODE_ROI && rcnt < 13'(rbsi_pkg::MaxRoi)) begin
            rsum <= rsum + 28'(rdata);
            rcnt <= rcnt + 13'd1;
          end
          state <= B_IDLE;
        end
        B_DIV: begin
          // restoring division by the background count, one bit a cycle
          if (dtrial >= {2'd0, bcnt}) begin
            drem <= 14'(dtrial - {2'd0, bcnt});
            dquo <= {dquo[31:0], 1'b1};
          end else begin
            drem <= dtrial[13:0];
            dquo <= {dquo[31:0], 1'b0};
          end
          dvd <= {dvd[31:0], 1'b0};
          dstep <= dstep + 6'd1;
          if (dstep == 6'd32) begin
            state <= B_MUL;
          end
        end
        B_MUL: begin
          mean <= ok ? dquo[19:0] : '0;
          prod <= 33'(dquo[19:0]) * 33'(rcnt);
          state <= B_OUT;
        end
        B_OUT: begin
          if (res_ready) begin
            rsum <= '0;
            bsum <= '0;
            rcnt <= '0;
            bcnt <= '0;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end
  `CHK_IMPL(cnt_bound, 1'b1, rcnt <= 13'(rbsi_pkg::MaxRoi) && bcnt <= 13'(rbsi_pkg::MaxRoi))
  `CHK_NEXT(clear_after, state == B_OUT && res_ready, rcnt == '0 && bcnt == '0)
endmodule
`default_nettype wire

// ----- tb/tb_roi_background_subtracted_intensity_unit.sv -----
// testbench for the roi background subtracted intensity unit: a queue-fed driver,
// a checking monitor and a predictor of frame store, sums and counts
// depends on rbsi_pkg and roi_background_subtracted_intensity_unit
`timescale 1ns / 1ps
module tb_roi_background_subtracted_intensity_unit;

  localparam int CycleLimit = 4000000;
  localparam int DrainCycles = 120;  // longer than a finish

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // mode[1:0], pixel_index[19:2], pixel_value[35:20], zero pad to 40
  logic [39:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // amplitude[32:0], background_mean[52:33], roi_pixel_count[65:53],
  // background_pixel_count[78:66], valid_res[79]
  logic [79:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = rbsi_pkg::REG_WIDTH;
  logic [9:0] cfg_data = '0;

  roi_background_subtracted_intensity_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // one finish report
  typedef struct packed {
    logic [32:0] amplitude;
    logic [19:0] mean;
    logic [12:0] roi_cnt;
    logic [12:0] bg_cnt;
    logic valid_res;
  } report_t;

  // predictor state
  logic [15:0] pixel_mem [0:rbsi_pkg::MaxPixels-1];
  bit written [0:rbsi_pkg::MaxPixels-1];  // generation side: entries already loaded
  int written_list[$];
  longint bg_sum, roi_sum;
  int bg_cnt, roi_cnt;
  int img_w = 512, img_h = 512, drift_x = 0, drift_y = 0;

  logic [39:0] pending_words[$];
  report_t expected_reports[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;

  // map a linear index to a store address after drift, 0 if out of bounds
  function automatic bit locate(input longint idx, output longint addr);
    longint xin, yin;
    addr = 0;
    if (img_w == 0) return 1'b0;
    xin = (idx % img_w) - drift_x;
    yin = (idx / img_w) - drift_y;
    if (xin < 0 || xin >= img_w || yin < 0 || yin >= img_h) return 1'b0;
    addr = yin * img_w + xin;
    return addr < rbsi_pkg::MaxPixels;
  endfunction

  // index word may never read an unloaded entry
  function automatic bit index_ok(input longint idx);
    longint a;
    if (!locate(idx, a)) return 1'b1;
    return written[a];
  endfunction

  // update sums, counts and store for one accepted word
  task automatic predict_word(input logic [39:0] w);
    rbsi_pkg::mode_t m;
    longint idx, a, mean, amp;
    report_t r;
    m = rbsi_pkg::mode_t'(w[1:0]);
    idx = w[19:2];
    case (m)
      rbsi_pkg::MODE_LOAD: begin
        pixel_mem[idx] = w[35:20];
      end
      rbsi_pkg::MODE_BG: begin
        if (bg_cnt < rbsi_pkg::MaxRoi && locate(idx, a)) begin
          bg_sum += pixel_mem[a];
          bg_cnt++;
        end
      end
      rbsi_pkg::MODE_ROI: begin
        if (roi_cnt < rbsi_pkg::MaxRoi && locate(idx, a)) begin
          roi_sum += pixel_mem[a];
          roi_cnt++;
        end
      end
      default: begin
        mean = 0;
        amp = 0;
        r.valid_res = 1'b0;
        if (roi_cnt != 0 && bg_cnt != 0) begin
          mean = (bg_sum * 16 + bg_cnt / 2) / bg_cnt;
          amp = roi_sum * 16 - mean * roi_cnt;
          r.valid_res = 1'b1;
        end
        r.amplitude = amp[32:0];
        r.mean = mean[19:0];
        r.roi_cnt = roi_cnt[12:0];
        r.bg_cnt = bg_cnt[12:0];
        expected_reports = {expected_reports, r};
        bg_sum = 0;
        roi_sum = 0;
        bg_cnt = 0;
        roi_cnt = 0;
      end
    endcase
  endtask

  // driver: predicts each accepted word, then offers the next one
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_word(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_words.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each report with the oldest expected one
  always @(posedge clk) begin
    report_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = report_t'({m_tdata[32:0], m_tdata[52:33], m_tdata[65:53],
                         m_tdata[78:66], m_tdata[79]});
        if (expected_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected report: %h", m_tdata);
        end else begin
          want = expected_reports.pop_front();
          if (got.amplitude !== want.amplitude || got.mean !== want.mean ||
              got.roi_cnt !== want.roi_cnt || got.bg_cnt !== want.bg_cnt ||
              got.valid_res !== want.valid_res) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: exp amp %h mean %h roi %0d bg %0d v %b, got %s",
                       want.amplitude, want.mean, want.roi_cnt, want.bg_cnt,
                       want.valid_res,
                       $sformatf("amp %h mean %h roi %0d bg %0d v %b",
                                 got.amplitude, got.mean, got.roi_cnt, got.bg_cnt,
                                 got.valid_res));
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_word(input rbsi_pkg::mode_t m, input longint idx, input int value);
    logic [17:0] i;
    logic [15:0] v;
    logic [39:0] w;
    i = idx[17:0];
    v = value[15:0];
    if (m == rbsi_pkg::MODE_LOAD && !written[i]) begin
      written[i] = 1'b1;
      written_list = {written_list, int'(i)};
    end
    w = {4'b0, v, i, 2'(m)};
    pending_words = {pending_words, w};
  endtask

  // wait until every word is taken and every report is back, then let the core settle
  task automatic drain();
    while (pending_words.size() > 0 || s_tvalid || expected_reports.size() > 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value[9:0];
    case (index)
      rbsi_pkg::REG_WIDTH: img_w = value & 10'h3ff;
      rbsi_pkg::REG_HEIGHT: img_h = value & 10'h3ff;
      rbsi_pkg::REG_XDRIFT:
        drift_x = (value & 10'h200) ? (value & 10'h3ff) - 1024 : (value & 10'h3ff);
      default:
        drift_y = (value & 10'h200) ? (value & 10'h3ff) - 1024 : (value & 10'h3ff);
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_frame(input int w, input int h, input int dx, input int dy);
    drain();
    write_reg(rbsi_pkg::REG_WIDTH, w);
    write_reg(rbsi_pkg::REG_HEIGHT, h);
    write_reg(rbsi_pkg::REG_XDRIFT, dx);
    write_reg(rbsi_pkg::REG_YDRIFT, dy);
  endtask

  // pick an index that reads a loaded pixel, or any index that is safe
  function automatic longint pick_index();
    longint a, x, y, idx;
    for (int t = 0; t < 40; t++) begin
      if ($urandom_range(99) < 75 && written_list.size() > 0 && img_w > 0) begin
        a = written_list[$urandom_range(written_list.size() - 1)];
        x = a % img_w + drift_x;
        y = a / img_w + drift_y;
        idx = y * img_w + x;
        if (x >= 0 && x < img_w && y >= 0 && idx < rbsi_pkg::MaxPixels && index_ok(idx))
          return idx;
      end else begin
        idx = $urandom_range(rbsi_pkg::MaxPixels - 1);
        if (index_ok(idx)) return idx;
      end
    end
    return -1;
  endfunction

  task automatic random_items(input int n);
    int done, span;
    longint idx;
    rbsi_pkg::mode_t m;
    done = 0;
    span = img_w * img_h;
    if (span <= 0 || span > rbsi_pkg::MaxPixels) span = rbsi_pkg::MaxPixels;
    while (done < n) begin
      if ($urandom_range(99) < 85) begin
        // well formed: loads, a run of indices, then a finish
        repeat ($urandom_range(12, 1)) begin
          push_word(rbsi_pkg::MODE_LOAD,
                    ($urandom_range(1) ? $urandom_range(span - 1)
                                       : $urandom_range(rbsi_pkg::MaxPixels - 1)),
                    $urandom_range(16'hffff));
          done++;
        end
        repeat ($urandom_range(16, 1)) begin
          idx = pick_index();
          if (idx >= 0) begin
            push_word($urandom_range(1) ? rbsi_pkg::MODE_BG : rbsi_pkg::MODE_ROI, idx,
                      $urandom_range(16'hffff));
            done++;
          end
        end
        push_word(rbsi_pkg::MODE_FINISH, $urandom_range(rbsi_pkg::MaxPixels - 1),
                  $urandom_range(16'hffff));
        done++;
      end else begin
        // noise
        m = rbsi_pkg::mode_t'($urandom_range(3));
        idx = $urandom_range(rbsi_pkg::MaxPixels - 1);
        if (m == rbsi_pkg::MODE_LOAD || m == rbsi_pkg::MODE_FINISH || index_ok(idx)) begin
          push_word(m, idx, $urandom_range(16'hffff));
          done++;
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: finish with nothing summed, extreme pixels and indices
    push_word(rbsi_pkg::MODE_FINISH, 0, 0);
    push_word(rbsi_pkg::MODE_LOAD, 0, 16'hffff);
    push_word(rbsi_pkg::MODE_LOAD, 18'h3ffff, 16'h1234);
    push_word(rbsi_pkg::MODE_LOAD, 1, 0);
    push_word(rbsi_pkg::MODE_LOAD, 511, 7);
    push_word(rbsi_pkg::MODE_BG, 0, 0);
    push_word(rbsi_pkg::MODE_BG, 1, 16'hffff);
    push_word(rbsi_pkg::MODE_ROI, 18'h3ffff, 0);
    push_word(rbsi_pkg::MODE_ROI, 511, 0);
    push_word(rbsi_pkg::MODE_FINISH, 18'h3ffff, 16'hffff);
    // background only, then roi only: both give an invalid report, as one count is zero
    push_word(rbsi_pkg::MODE_BG, 0, 0);
    push_word(rbsi_pkg::MODE_FINISH, 0, 0);
    push_word(rbsi_pkg::MODE_ROI, 0, 0);
    push_word(rbsi_pkg::MODE_FINISH, 0, 0);
    // zero width: everything out of bounds
    set_frame(0, 512, 0, 0);
    push_word(rbsi_pkg::MODE_BG, 0, 0);
    push_word(rbsi_pkg::MODE_ROI, 1, 0);
    push_word(rbsi_pkg::MODE_FINISH, 0, 0);
    // wide frame with negative drift: reads fall past the end of the store
    set_frame(1023, 1023, -5, -300);
    push_word(rbsi_pkg::MODE_BG, 18'h3ffff, 0);
    push_word(rbsi_pkg::MODE_ROI, 18'h3ffff, 0);
    push_word(rbsi_pkg::MODE_FINISH, 0, 0);

    // random phases over several frame settings and idling patterns
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_frame(512, 512, 0, 0);
        1: set_frame(1, 512, 0, 511);
        2: set_frame(512, 1, -511, 0);
        3: set_frame(37, 90, 3, -2);
        4: set_frame(512, 512, 511, -511);
        5: set_frame(1023, 300, -511, 511);
        6: set_frame(200, 200, -7, 9);
        default: set_frame(64, 64, 0, 0);
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 69; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 69; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      random_items(200);
    end

    drain();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
